### hw/rtl/circular_deque_indexed_top_macros.svh
`ifndef CIRCULAR_DEQUE_INDEXED_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_INDEXED_TOP_MACROS_SVH

// same-cycle implication
`define CDI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cdi_pkg.sv
package cdi_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_WRITE      = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } st_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } out_word_t;

  typedef struct packed {
    logic               we;
    logic               re;
    st_e                status;
    logic [COUNT_W-1:0] count;
  } op_info_t;

endpackage

### hw/rtl/cdi_ptr_ctrl.sv
module cdi_ptr_ctrl #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  cdi_pkg::in_word_t        word_i,
  output cdi_pkg::op_info_t        info_o,
  output logic [$clog2(DEPTH)-1:0] addr_o,
  output logic [DATA_WIDTH-1:0]    wdata_o
);
  import cdi_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          full, empty, in_range;
  logic [AW-1:0] off, phys, head_dec;
  logic [AW:0]   off_sum;
  cmd_e          cmd;

  always_comb begin
    cmd      = cmd_e'(word_i.command);
    full     = (fill_q == CW'(DEPTH));
    empty    = (fill_q == '0);
    in_range = (POS_W'(fill_q) > word_i.position);
    head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

    unique case (cmd)
      CMD_PUSH_BACK: off = AW'(fill_q);
      CMD_POP_FRONT: off = AW'(1);
      default:       off = word_i.position[AW-1:0];
    endcase

    // logical offset to physical slot, one wrap at most
    off_sum = {1'b0, head_q} + {1'b0, off};
    phys    = (off_sum >= (AW+1)'(DEPTH)) ? AW'(off_sum - (AW+1)'(DEPTH)) : AW'(off_sum);
  end

  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    addr_o      = phys;
    info_o.we     = 1'b0;
    info_o.re     = 1'b0;
    info_o.status = ST_OK;
    unique case (cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          info_o.status = ST_FULL;
        end else begin
          info_o.we = 1'b1;
          fill_d    = fill_q + CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          info_o.status = ST_FULL;
        end else begin
          head_d    = head_dec;
          addr_o    = head_dec;
          info_o.we = 1'b1;
          fill_d    = fill_q + CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          info_o.status = ST_EMPTY;
        end else begin
          fill_d = fill_q - CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          info_o.status = ST_EMPTY;
        end else begin
          head_d = phys;
          fill_d = fill_q - CW'(1);
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          info_o.status = ST_RANGE;
        end else begin
          info_o.re = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (!in_range) begin
          info_o.status = ST_RANGE;
        end else begin
          info_o.we = 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_d = '0;
        fill_d = '0;
      end
      default: begin
      end
    endcase
    info_o.count = COUNT_W'(fill_d);
  end

  assign wdata_o = DATA_WIDTH'(word_i.value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else if (accept_i) begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

endmodule

### hw/rtl/circular_deque_indexed_top.sv
// an accepted word is registered in the read stage and then in the output register
// throughput: one command per cycle while the output is not stalled; the slot memory read is issued at acceptance
// and its registered data meets the command's status in the output register
// a stalled output holds both stages, the input stalls once both hold a word
// reset clears head, fill and all valid flags; slot contents are not cleared
`include "circular_deque_indexed_top_macros.svh"

module circular_deque_indexed_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cdi_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cdi_pkg::out_word_t out_data_o
);
  import cdi_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic                  accept;
  logic                  s1_adv;
  op_info_t              info;
  logic [AW-1:0]         addr;
  logic [DATA_WIDTH-1:0] wdata;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic                  s1_valid_q;
  op_info_t              s1_info_q;
  logic                  out_valid_q;
  out_word_t             out_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  cdi_ptr_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ptr_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_data_i),
    .info_o   (info),
    .addr_o   (addr),
    .wdata_o  (wdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept && info.we) begin
      mem_q[addr] <= wdata;
    end
    if (accept && info.re) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
    end
    if (s1_valid_q && s1_adv) begin
      out_q.read_value <= s1_info_q.re ? VAL_W'(rdata_q) : '0;
      out_q.status     <= s1_info_q.status;
      out_q.count      <= s1_info_q.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept || s1_adv) begin
        s1_valid_q <= accept;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CDI_ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, accept, s1_valid_q,
    "accepted word did not reach the read stage")
  `CDI_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_adv,
    s1_valid_q && $stable(s1_info_q) && (!s1_info_q.re || $stable(rdata_q)),
    "held read stage changed")
  `CDI_ASSERT_NEXT(a_s1_moves, clk_i, rst_ni, s1_valid_q && s1_adv, out_valid_q,
    "read stage word lost on its way to the output")
  `CDI_ASSERT_NOW(a_err_reads_zero, clk_i, rst_ni,
    out_valid_o && (out_data_o.status != ST_OK), out_data_o.read_value == '0,
    "failed command returned nonzero read value")

endmodule

### test/cdi_checker.sv
module cdi_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  cdi_pkg::in_word_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  cdi_pkg::out_word_t out_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);
  import cdi_pkg::*;

  localparam int unsigned DEPTH = 16;

  logic [VAL_W-1:0]   deque_slots [DEPTH];
  logic [3:0]         front_idx;
  logic [COUNT_W-1:0] elem_cnt;
  out_word_t          result_q [$];
  out_word_t          want;

  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t  r;
    logic [3:0] slot;
    r.read_value = '0;
    r.status     = ST_OK;
    slot         = front_idx + w.position[3:0];
    case (w.command)
      CMD_PUSH_BACK: begin
        if (elem_cnt == COUNT_W'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          slot = front_idx + elem_cnt[3:0];
          deque_slots[slot] = w.value;
          elem_cnt++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (elem_cnt == COUNT_W'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          front_idx = front_idx - 4'd1;
          deque_slots[front_idx] = w.value;
          elem_cnt++;
        end
      end
      CMD_POP_BACK: begin
        if (elem_cnt == '0) r.status = ST_EMPTY;
        else elem_cnt--;
      end
      CMD_POP_FRONT: begin
        if (elem_cnt == '0) begin
          r.status = ST_EMPTY;
        end else begin
          front_idx = front_idx + 4'd1;
          elem_cnt--;
        end
      end
      CMD_READ: begin
        if (w.position >= elem_cnt) r.status = ST_RANGE;
        else r.read_value = deque_slots[slot];
      end
      CMD_WRITE: begin
        if (w.position >= elem_cnt) r.status = ST_RANGE;
        else deque_slots[slot] = w.value;
      end
      CMD_CLEAR: begin
        front_idx = '0;
        elem_cnt  = '0;
      end
      default: ;
    endcase
    r.count = elem_cnt;
    return r;
  endfunction

  // result side first: a result never belongs to a word taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx = '0;
      elem_cnt  = '0;
      result_q.delete();
      errors_o  = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          errors_o++;
          $error("result word with nothing expected: %h", out_data_i);
        end else begin
          want = result_q.pop_front();
          checked_o++;
          if (out_data_i.read_value !== want.read_value) begin
            errors_o++;
            $error("read_value: expected %h, got %h", want.read_value,
                   out_data_i.read_value);
          end
          if (out_data_i.status !== want.status) begin
            errors_o++;
            $error("status: expected %0d, got %0d", want.status, out_data_i.status);
          end
          if (out_data_i.count !== want.count) begin
            errors_o++;
            $error("count: expected %0d, got %0d", want.count, out_data_i.count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) result_q.push_back(apply_command(in_data_i));
      pending_o = result_q.size();
    end
  end

endmodule

### test/tb_circular_deque_indexed_top.sv
module tb_circular_deque_indexed_top;
  import cdi_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int N_RANDOM = 720;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  int errors;
  int pending;
  int checked;
  int sent_by_cmd [8];
  int longest_hold;

  always #4 clk_i = ~clk_i;

  circular_deque_indexed_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  cdi_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // phase 0 fills, phase 1 drains, phase 2 favours indexed access
  function automatic logic [CMD_W-1:0] pick_cmd(input int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (r < 35) return CMD_PUSH_BACK;
        if (r < 65) return CMD_PUSH_FRONT;
        if (r < 72) return CMD_POP_BACK;
        if (r < 78) return CMD_POP_FRONT;
        if (r < 88) return CMD_READ;
        if (r < 96) return CMD_WRITE;
        if (r < 98) return CMD_CLEAR;
        return CMD_UNUSED;
      end
      1: begin
        if (r < 10) return CMD_PUSH_BACK;
        if (r < 20) return CMD_PUSH_FRONT;
        if (r < 45) return CMD_POP_BACK;
        if (r < 70) return CMD_POP_FRONT;
        if (r < 82) return CMD_READ;
        if (r < 94) return CMD_WRITE;
        if (r < 97) return CMD_CLEAR;
        return CMD_UNUSED;
      end
      default: begin
        if (r < 15) return CMD_PUSH_BACK;
        if (r < 30) return CMD_PUSH_FRONT;
        if (r < 38) return CMD_POP_BACK;
        if (r < 46) return CMD_POP_FRONT;
        if (r < 70) return CMD_READ;
        if (r < 94) return CMD_WRITE;
        if (r < 97) return CMD_CLEAR;
        return CMD_UNUSED;
      end
    endcase
  endfunction

  function automatic in_word_t mk(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                                  input logic [VAL_W-1:0] v);
    in_word_t w;
    w.command  = c;
    w.position = p;
    w.value    = v;
    return w;
  endfunction

  function automatic in_word_t random_word(input int phase);
    in_word_t w;
    int       r;
    w.command = pick_cmd(phase);
    r = $urandom_range(0, 99);
    if (r < 70) w.position = POS_W'($urandom_range(0, 17));
    else if (r < 85) w.position = POS_W'($urandom_range(0, 3));
    else w.position = POS_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) w.value = '0;
    else if (r == 1) w.value = '1;
    else w.value = $urandom;
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input in_word_t w, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sent_by_cmd[w.command]++;
    @(negedge clk_i);
  endtask

  initial begin
    int phase;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    phase      = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty deque
    send_word(mk(CMD_POP_BACK, '0, '0), pick_gap());
    send_word(mk(CMD_POP_FRONT, '0, '0), pick_gap());
    send_word(mk(CMD_READ, '0, '0), pick_gap());
    send_word(mk(CMD_WRITE, '1, '1), pick_gap());
    // fill to capacity from both ends
    send_word(mk(CMD_PUSH_BACK, '0, '1), pick_gap());
    send_word(mk(CMD_PUSH_FRONT, '1, '0), pick_gap());
    for (int k = 0; k < 14; k++) begin
      send_word(mk((k % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, POS_W'($urandom), $urandom),
                pick_gap());
    end
    // full deque
    send_word(mk(CMD_PUSH_BACK, '0, 32'h1234_5678), pick_gap());
    send_word(mk(CMD_PUSH_FRONT, '0, 32'h8765_4321), pick_gap());
    send_word(mk(CMD_READ, 16'd15, '0), pick_gap());
    send_word(mk(CMD_READ, 16'd16, '0), pick_gap());
    send_word(mk(CMD_WRITE, '0, 32'hA5A5_5A5A), pick_gap());
    send_word(mk(CMD_UNUSED, '1, '1), pick_gap());
    send_word(mk(CMD_CLEAR, '0, '0), pick_gap());
    send_word(mk(CMD_READ, '0, '0), pick_gap());

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) phase = $urandom_range(0, 2);
      if (i == 500) begin
        // let every outstanding result come out before going on
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
      end
      send_word(random_word(phase), (i >= 100 && i < 200) ? 0 : pick_gap());
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("covered %0d commands: %0d push back, %0d push front, %0d pop back, %0d pop front,",
             sent_by_cmd.sum(), sent_by_cmd[CMD_PUSH_BACK], sent_by_cmd[CMD_PUSH_FRONT],
             sent_by_cmd[CMD_POP_BACK], sent_by_cmd[CMD_POP_FRONT]);
    $display("  %0d read, %0d write, %0d clear, %0d unused code; %0d results checked, hold %0d",
             sent_by_cmd[CMD_READ], sent_by_cmd[CMD_WRITE], sent_by_cmd[CMD_CLEAR],
             sent_by_cmd[CMD_UNUSED], checked, longest_hold);
    if (errors == 0) begin
      $display("tb_circular_deque_indexed_top OK");
    end else begin
      $display("tb_circular_deque_indexed_top NOT OK");
    end
    $finish;
  end

  // receiver stalls; one long hold-off while the sender keeps offering words
  initial begin
    int cyc;
    int hold_left;
    out_stall_i  = 1'b0;
    cyc          = 0;
    hold_left    = 0;
    longest_hold = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 300) hold_left = 90;
      else if (hold_left == 0 && (cyc / 250) % 3 != 0 && $urandom_range(0, 3) == 0)
        hold_left = pick_gap();
      if (hold_left > longest_hold) longest_hold = hold_left;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #5000000;
    $display("tb_circular_deque_indexed_top NOT OK");
    $finish;
  end

endmodule
